// ----- rtl/met_pkg.sv -----
package met_pkg;

    localparam int FRAC_BITS  = 26;
    localparam int COORD_W    = 32;
    localparam int C_W        = 30;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int LIMIT_W    = 8;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    // |z|^2 > 16 with 2*FRAC_BITS fraction bits
    localparam logic [PROD_W-1:0] ESC_BOUND = PROD_W'(16) << (2 * FRAC_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } met_state_t;

    typedef struct packed {
        logic load;    // capture c, clear z and count
        logic mul;     // register the three products of z
        logic upd;     // z <= z*z + c, count++
        logic finish;  // write result to output register
    } met_cmd_t;

    typedef struct packed {
        logic escaped;   // |z|^2 > 16 on current products
        logic at_limit;  // update count reached the limit
        logic out_free;  // output register can take a result
    } met_status_t;

endpackage

// ----- rtl/met_ctrl.sv -----
module met_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  met_pkg::met_status_t status,
    output met_pkg::met_cmd_t    cmd
);
    import met_pkg::*;

    met_state_t state_reg;
    met_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (status.escaped || status.at_limit)
                begin
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_UPD:
            begin
                if (status.escaped || status.at_limit)
                begin
                    cmd.finish = status.out_free;
                end
                else
                begin
                    cmd.upd = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.upd, cmd.finish}))
        else $error("more than one datapath command");

    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_UPD))
        else $error("multiply not followed by update");

    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE))
        else $error("load outside idle");

endmodule

// ----- rtl/met_dp.sv -----
module met_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [met_pkg::C_W-1:0]       c_re,
    input  logic [met_pkg::C_W-1:0]       c_im,
    input  logic [met_pkg::LIMIT_W-1:0]   limit,
    input  met_pkg::met_cmd_t             cmd,
    output met_pkg::met_status_t          status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          inside_res
);
    import met_pkg::*;

    logic signed [C_W-1:0]     c_re_reg;
    logic signed [C_W-1:0]     c_im_reg;
    logic signed [COORD_W-1:0] z_re_reg;
    logic signed [COORD_W-1:0] z_im_reg;
    logic signed [PROD_W-1:0]  sq_re_reg;
    logic signed [PROD_W-1:0]  sq_im_reg;
    logic signed [PROD_W-1:0]  cross_reg;
    logic [LIMIT_W-1:0]        cnt_reg;
    logic                      out_valid_reg;
    logic                      res_reg;

    logic signed [PROD_W-1:0]  sq_re_next;
    logic signed [PROD_W-1:0]  sq_im_next;
    logic signed [PROD_W-1:0]  cross_next;
    logic signed [PROD_W-1:0]  diff;
    logic signed [PROD_W-1:0]  re_shift;
    logic signed [PROD_W-1:0]  im_shift;
    logic signed [COORD_W-1:0] z_re_next;
    logic signed [COORD_W-1:0] z_im_next;
    logic [PROD_W-1:0]         mag_sq;

    // one shared set of 32x32 multipliers, products registered
    assign sq_re_next = z_re_reg * z_re_reg;
    assign sq_im_next = z_im_reg * z_im_reg;
    assign cross_next = z_re_reg * z_im_reg;

    // floor shift; 2*x*y folds into one less bit of shift
    assign diff      = sq_re_reg - sq_im_reg;
    assign re_shift  = diff >>> FRAC_BITS;
    assign im_shift  = cross_reg >>> (FRAC_BITS - 1);
    assign z_re_next = re_shift[COORD_W-1:0] + COORD_W'(c_re_reg);
    assign z_im_next = im_shift[COORD_W-1:0] + COORD_W'(c_im_reg);

    // squares are non-negative and at most 2^62, sum cannot wrap
    assign mag_sq = sq_re_reg + sq_im_reg;

    assign status.escaped  = (mag_sq > ESC_BOUND);
    assign status.at_limit = (cnt_reg == limit);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_re_reg <= c_re;
            c_im_reg <= c_im;
            z_re_reg <= '0;
            z_im_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.upd)
        begin
            z_re_reg <= z_re_next;
            z_im_reg <= z_im_next;
            cnt_reg  <= cnt_reg + LIMIT_W'(1);
        end
        if (cmd.mul)
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            cross_reg <= cross_next;
        end
        if (cmd.finish)
        begin
            res_reg <= !status.escaped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = res_reg;

    a_upd_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> (cnt_reg < limit))
        else $error("update past iteration limit");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");

    a_finish_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> status.out_free)
        else $error("result overwrote a pending beat");

endmodule

// ----- rtl/mandelbrot_escape_test_unit.sv -----
// Mandelbrot escape test: z <= z*z + c from z = 0, up to iteration_limit times.
// One point at a time: a new point is taken only while idle. The loop alternates
//   a multiply state on the shared 32x32 multipliers with an update/escape-check
//   state until the point escapes or iteration_limit updates have run; the result
//   write waits while the output register still holds an unaccepted result.
// Reset (rst_n, async low): idle, no result pending, iteration_limit = 32.
module mandelbrot_escape_test_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // input point
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [met_pkg::S_DATA_W-1:0]    s_tdata,   // [29:0] c_re, [59:30] c_im, [63:60] zero
    // result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [met_pkg::M_DATA_W-1:0]    m_tdata,   // [0] inside_res, [7:1] zero
    // iteration_limit register
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [met_pkg::LIMIT_W-1:0]     cfg_data
);
    import met_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    met_cmd_t           cmd;
    met_status_t        status;
    logic               inside_res;

    // register is always writable; write it only while idle, a rule the block leaves to the user
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    met_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    met_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .c_re       (s_tdata[C_W-1:0]),
        .c_im       (s_tdata[2*C_W-1:C_W]),
        .limit      (limit_reg),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .inside_res (inside_res)
    );

    // result beat: flag in bit 0
    assign m_tdata = {(M_DATA_W - 1)'(0), inside_res};

endmodule

// ----- sim/mandelbrot_escape_test_unit_test.sv -----
`timescale 1ns / 1ps

// Checks the Mandelbrot escape test unit against a behavioral predictor of
// the z = z*z + c loop. Points go in on the s_* stream, one flag per point
// comes back on m_*. The iteration limit is changed between phases, only
// once every outstanding flag has come back. Both stream sides idle at random,
// except for one phase that runs with no idling at all.
module mandelbrot_escape_test_unit_test;
    import met_pkg::*;

    localparam int     HALF_PERIOD = 6;
    localparam int     IDLE_PCT    = 25;          // percent of cycles a side idles
    localparam longint ONE         = longint'(1) << FRAC_BITS;          // 1.0
    localparam longint ESCAPE_SQ   = longint'(16) << (2 * FRAC_BITS);   // |z|^2 bound
    localparam longint C_MIN       = -(longint'(1) << (C_W - 1));
    localparam longint C_MAX       = (longint'(1) << (C_W - 1)) - 1;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;   // [29:0] c_re, [59:30] c_im, [63:60] zero
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;   // [0] inside_res, [7:1] zero
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        cfg_data;

    // Flags still owed by the unit, oldest first, and the limit the
    // predictor runs with (tracks what was last written to the unit).
    bit                bounded_expected[$];
    logic [LIMIT_W-1:0] limit_model = LIMIT_RESET;

    bit                calm;            // no idling on either side while set
    int                points_sent;
    int                results_seen;
    int                inside_seen;
    int                limit_writes;
    int                errors;
    bit                want;

    mandelbrot_escape_test_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Escape-time predictor. z starts at 0; each update is
    // z_re' = floor((x^2 - y^2) / 2^F) + c_re, z_im' = floor(2xy / 2^F) + c_im,
    // then |z'|^2 > 16 (exact, no square root) means the point escaped.
    // Before an escape |z| <= 4, so every product stays well inside 64 bits.
    function automatic bit point_stays_bounded(input logic [C_W-1:0] re_bits,
                                               input logic [C_W-1:0] im_bits,
                                               input logic [LIMIT_W-1:0] max_updates);
        longint cr;
        longint ci;
        longint zr;
        longint zi;
        longint next_re;
        longint next_im;
        cr = longint'($signed(re_bits));
        ci = longint'($signed(im_bits));
        zr = 0;
        zi = 0;
        for (int n = 0; n < max_updates; n++)
        begin
            next_re = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
            next_im = ((2 * zr * zi) >>> FRAC_BITS) + ci;
            zr = next_re;
            zi = next_im;
            if (zr * zr + zi * zi > ESCAPE_SQ)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // One point beat. Starts and ends at a falling edge. tvalid is left high
    // after the beat so back-to-back points need no drop in between.
    task automatic send_point(input longint re, input longint im);
        logic [C_W-1:0] re_bits;
        logic [C_W-1:0] im_bits;
        re_bits = re[C_W-1:0];
        im_bits = im[C_W-1:0];
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};   // junk while idle, must be ignored
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, im_bits, re_bits};
        do @(posedge clk); while (!s_tready);
        bounded_expected.push_back(point_stays_bounded(re_bits, im_bits, limit_model));
        points_sent++;
        @(negedge clk);
    endtask

    // Limit writes happen only with the unit idle: stream held off and every
    // flag back. Each point yields a flag, so an empty queue means idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        s_tvalid = 1'b0;
        while (bounded_expected.size() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid   = 1'b0;
        limit_model = value;
        limit_writes++;
    endtask

    // Random point: mostly the region around the set, where escape times
    // vary most; some points from a box near the origin, mostly interior ones
    // that run the full limit; the rest any 30-bit pattern at all.
    task automatic pick_point(output longint re, output longint im);
        int unsigned    kind;
        logic [C_W-1:0] raw;
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            re = longint'($urandom_range(0, 3 * ONE)) - 2 * ONE - ONE / 4;
            im = longint'($urandom_range(0, 3 * ONE)) - 3 * ONE / 2;
        end
        else if (kind < 75)
        begin
            re = longint'($urandom_range(0, 3 * ONE / 4)) - ONE / 2;
            im = longint'($urandom_range(0, ONE)) - ONE / 2;
        end
        else
        begin
            raw = C_W'($urandom);
            re  = longint'($signed(raw));
            raw = C_W'($urandom);
            im  = longint'($signed(raw));
        end
    endtask

    // Reset limit of 32: corners of the coordinate range, the exact |z| = 4
    // boundary, classic interior orbits and toggling bit patterns.
    task automatic test_directed_points();
        send_point(0, 0);
        send_point(-2 * ONE, 0);           // orbit -2, 2, 2, ... on |z|^2 = 4
        send_point(-2 * ONE - 1, 0);       // just past the tip, escapes late
        send_point(4 * ONE, 0);            // |z| exactly 4 first, not an escape
        send_point(4 * ONE + 1, 0);        // escapes on the first update
        send_point(0, 4 * ONE);
        send_point(0, -4 * ONE - 1);
        send_point(ONE / 4, 0);            // cusp, slow convergence
        send_point(ONE / 4 + 1, 0);
        send_point(-ONE, 0);               // period-two orbit
        send_point(0, ONE);                // orbit through -1+i and -i
        send_point(-3 * ONE / 4, ONE / 10);
        send_point(C_MIN, C_MIN);
        send_point(C_MAX, C_MAX);
        send_point(C_MIN, C_MAX);
        send_point(C_MAX, C_MIN);
        send_point(longint'(30'h2AAA_AAAA), longint'(30'h1555_5555));
        send_point(longint'(30'h1555_5555), longint'(30'h2AAA_AAAA));
    endtask

    // With a limit of 0 no update runs, so every point reads as inside.
    task automatic test_zero_limit();
        write_limit(8'd0);
        send_point(C_MAX, C_MIN);
        send_point(4 * ONE + 1, 0);
    endtask

    // A single update: only c itself is tested against the bound.
    task automatic test_single_update();
        write_limit(8'd1);
        send_point(4 * ONE, 0);
        send_point(2 * ONE, 7 * ONE / 2);
        send_point(-4 * ONE, 1);
    endtask

    // Phases of random points, each under its own limit: the largest limit,
    // the smallest, one phase with no idling, the rest mostly short limits.
    task automatic test_random_sweep();
        longint re;
        longint im;
        int     count;
        for (int phase = 0; phase < 10; phase++)
        begin
            count = 115;
            case (phase)
                0:       begin write_limit(8'd255); count = 60; end
                1:       write_limit(8'd1);
                4:       write_limit(8'($urandom_range(16, 48)));
                9:       write_limit(8'($urandom_range(1, 255)));
                default: write_limit(8'($urandom_range(2, 40)));
            endcase
            calm = (phase == 4);
            for (int k = 0; k < count; k++)
            begin
                pick_point(re, im);
                send_point(re, im);
            end
            calm = 1'b0;
        end
    endtask

    // Result side: hold tready low on about a quarter of the cycles.
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Every flag beat is matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[0])
                inside_seen++;
            if (bounded_expected.size() == 0)
                report_mismatch($sformatf("flag beat %0d with no point outstanding",
                                          results_seen));
            else
            begin
                want = bounded_expected.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("flag beat %0d: inside_res %b, expected %b",
                                              results_seen, m_tdata[0], want));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #15_000_000;
        $display("Timeout with %0d flags outstanding", bounded_expected.size());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_points();
        test_zero_limit();
        test_single_update();
        test_random_sweep();

        // Drain: all flags back, then a full worst-case point time of quiet
        // so any stray beat still shows up.
        s_tvalid = 1'b0;
        while (bounded_expected.size() != 0)
            @(negedge clk);
        repeat (2 * (255 + 1) + 8) @(negedge clk);
        if (bounded_expected.size() != 0)
            report_mismatch($sformatf("%0d flags never arrived", bounded_expected.size()));

        $display("Sent %0d points under %0d limit settings (0, 1, 255 among them).",
                 points_sent, limit_writes + 1);
        $display("Checked %0d flags: %0d inside, %0d escaped; %0d mismatches.",
                 results_seen, inside_seen, results_seen - inside_seen, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/met_pkg.sv
rtl/met_ctrl.sv
rtl/met_dp.sv
rtl/mandelbrot_escape_test_unit.sv
sim/mandelbrot_escape_test_unit_test.sv
